[hdl/hsv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_pkg: shared types and constants for the HSV to RGB555 pixel pipeline
// Sector codes, field widths and the reciprocal constants used for the
// exact divisions by 65025 and by 975375 (65025 * 15).
// ----------------------------------------------------------------------------
package hsv_pkg;

  localparam int unsigned HueW   = 13;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned Chan5W = 5;
  localparam int unsigned PixW   = 16;
  localparam int unsigned ProdW  = 16;   // bri * sat, at most 65025
  localparam int unsigned PosW   = 11;   // hue mod 1920
  localparam int unsigned WgtW   = 10;   // 960 - distance, at most 960

  localparam logic [HueW-1:0] SectorSpan = 13'd960;
  localparam logic [PosW-1:0] SpanNarrow = 11'd960;
  localparam logic [PosW-1:0] PairSpan   = 11'd1920;
  localparam logic [PixW-1:0] MarkerBit  = 16'h8000;

  // floor(31 * n / 65025) = (n * CScaleMult) >> CShift for n <= 65025
  localparam int unsigned    CShift     = 37;
  localparam int unsigned    CMultW     = 27;
  localparam int unsigned    CProdW     = ProdW + CMultW;
  localparam logic [63:0]    CRecip     = ((64'd1 << CShift) + 64'd65024) / 64'd65025;
  localparam logic [CMultW-1:0] CScaleMult = CMultW'(CRecip * 64'd31);

  // floor(m / 975375) = (m * XMult) >> XShift for m < 2^25
  localparam int unsigned    XNumW   = 25;
  localparam int unsigned    XShift  = 45;
  localparam int unsigned    XMultW  = 26;
  localparam int unsigned    XProdW  = XNumW + XMultW;
  localparam logic [63:0]    XRecip  = ((64'd1 << XShift) + 64'd975374) / 64'd975375;
  localparam logic [XMultW-1:0] XMult = XMultW'(XRecip);

  localparam int unsigned    PwW     = ProdW + WgtW;   // p * w
  localparam int unsigned    Pw31W   = PwW + 5;        // 31 * p * w

  typedef enum logic [2:0] {
    SECT_0     = 3'd0,
    SECT_1     = 3'd1,
    SECT_2     = 3'd2,
    SECT_3     = 3'd3,
    SECT_4     = 3'd4,
    SECT_5     = 3'd5,
    SECT_BLACK = 3'd6
  } sector_e;

  typedef struct packed {
    logic en_a;
    logic en_b;
    logic en_c;
    logic en_d;
  } stage_en_t;

endpackage

[hdl/hsv_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_front: first pipeline stage
// Decode the hue sector, fold the hue into one sector pair and form the
// chroma and offset products bri*sat and bri*(255-sat).
// ----------------------------------------------------------------------------
module hsv_front (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [hsv_pkg::HueW-1:0]      hue_i,
  input  logic [hsv_pkg::ChanW-1:0]     sat_i,
  input  logic [hsv_pkg::ChanW-1:0]     bri_i,
  output hsv_pkg::sector_e              sector_o,
  output logic [hsv_pkg::PosW-1:0]      pos_o,
  output logic [hsv_pkg::ProdW-1:0]     cprod_o,
  output logic [hsv_pkg::ProdW-1:0]     mprod_o
);
  import hsv_pkg::*;

  sector_e             sector_d, sector_q;
  logic [HueW-1:0]     base;
  logic [PosW-1:0]     pos_d, pos_q;
  logic [ProdW-1:0]    cprod_d, cprod_q, mprod_d, mprod_q;
  logic [ChanW-1:0]    sat_inv;

  always_comb begin
    priority if (hue_i < SectorSpan) begin
      sector_d = SECT_0;
      base     = '0;
    end else if (hue_i < 13'(2 * SectorSpan)) begin
      sector_d = SECT_1;
      base     = '0;
    end else if (hue_i < 13'(3 * SectorSpan)) begin
      sector_d = SECT_2;
      base     = 13'(2 * SectorSpan);
    end else if (hue_i < 13'(4 * SectorSpan)) begin
      sector_d = SECT_3;
      base     = 13'(2 * SectorSpan);
    end else if (hue_i < 13'(5 * SectorSpan)) begin
      sector_d = SECT_4;
      base     = 13'(4 * SectorSpan);
    end else if (hue_i < 13'(6 * SectorSpan)) begin
      sector_d = SECT_5;
      base     = 13'(4 * SectorSpan);
    end else begin
      sector_d = SECT_BLACK;
      base     = '0;
    end
  end

  always_comb begin
    logic [HueW-1:0] diff;
    diff    = hue_i - base;
    pos_d   = diff[PosW-1:0];
    sat_inv = ~sat_i;
    cprod_d = ProdW'(bri_i) * ProdW'(sat_i);
    mprod_d = ProdW'(bri_i) * ProdW'(sat_inv);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sector_q <= sector_d;
      pos_q    <= pos_d;
      cprod_q  <= cprod_d;
      mprod_q  <= mprod_d;
    end
  end

  assign sector_o = sector_q;
  assign pos_o    = pos_q;
  assign cprod_o  = cprod_q;
  assign mprod_o  = mprod_q;

endmodule

[hdl/hsv_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_scale: second and third pipeline stages
// Scale chroma and offset by 31/65025 through a reciprocal multiply, form
// the hue weight product, scale it by 31 and divide it by 65025*960 in two steps.
// ----------------------------------------------------------------------------
module hsv_scale (
  input  logic                          clk_i,
  input  hsv_pkg::stage_en_t            en_i,
  input  hsv_pkg::sector_e              sector_i,
  input  logic [hsv_pkg::PosW-1:0]      pos_i,
  input  logic [hsv_pkg::ProdW-1:0]     cprod_i,
  input  logic [hsv_pkg::ProdW-1:0]     mprod_i,
  output hsv_pkg::sector_e              sector_o,
  output logic [hsv_pkg::Chan5W-1:0]    c5_o,
  output logic [hsv_pkg::Chan5W-1:0]    m5_o,
  output logic [hsv_pkg::XProdW-1:0]    xprod_o
);
  import hsv_pkg::*;

  // stage B
  sector_e            sector_b_q;
  logic [WgtW-1:0]    wgt;
  logic [CProdW-1:0]  cscl_q, mscl_q;
  logic [PwW-1:0]     pw_q;
  // stage C
  sector_e            sector_c_q;
  logic [Chan5W-1:0]  c5_q, m5_q;
  logic [XProdW-1:0]  xprod_q;
  logic [Pw31W-1:0]   pw31;
  logic [XNumW-1:0]   xnum;

  // weight = 960 - |pos - 960|
  always_comb begin
    logic [PosW-1:0] w_full;
    w_full = (pos_i < SpanNarrow) ? pos_i : (PairSpan - pos_i);
    wgt    = w_full[WgtW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_b) begin
      sector_b_q <= sector_i;
      cscl_q     <= CProdW'(cprod_i) * CProdW'(CScaleMult);
      mscl_q     <= CProdW'(mprod_i) * CProdW'(CScaleMult);
      pw_q       <= PwW'(cprod_i) * PwW'(wgt);
    end
  end

  // 31 * p * w, then drop the factor 64 of 960 exactly
  assign pw31 = {pw_q, 5'b0} - Pw31W'(pw_q);
  assign xnum = pw31[Pw31W-1 -: XNumW];

  always_ff @(posedge clk_i) begin
    if (en_i.en_c) begin
      sector_c_q <= sector_b_q;
      c5_q       <= cscl_q[CShift +: Chan5W];
      m5_q       <= mscl_q[CShift +: Chan5W];
      xprod_q    <= XProdW'(xnum) * XProdW'(XMult);
    end
  end

  assign sector_o = sector_c_q;
  assign c5_o     = c5_q;
  assign m5_o     = m5_q;
  assign xprod_o  = xprod_q;

endmodule

[hdl/hsv_mix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_mix: last pipeline stage
// Add the offset, route the three levels to red, green and blue by sector
// and pack the pixel word into the output register.
// ----------------------------------------------------------------------------
module hsv_mix (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  hsv_pkg::sector_e              sector_i,
  input  logic [hsv_pkg::Chan5W-1:0]    c5_i,
  input  logic [hsv_pkg::Chan5W-1:0]    m5_i,
  input  logic [hsv_pkg::XProdW-1:0]    xprod_i,
  output logic [hsv_pkg::PixW-1:0]      pixel_o
);
  import hsv_pkg::*;

  logic [Chan5W-1:0] x5, cm, xm, red, grn, blu;
  logic [PixW-1:0]   pixel_d, pixel_q;

  assign x5 = xprod_i[XShift +: Chan5W];
  assign cm = c5_i + m5_i;
  assign xm = x5 + m5_i;

  always_comb begin
    unique case (sector_i)
      SECT_0:     begin red = cm;   grn = xm;   blu = m5_i; end
      SECT_1:     begin red = xm;   grn = cm;   blu = m5_i; end
      SECT_2:     begin red = m5_i; grn = cm;   blu = xm;   end
      SECT_3:     begin red = m5_i; grn = xm;   blu = cm;   end
      SECT_4:     begin red = xm;   grn = m5_i; blu = cm;   end
      SECT_5:     begin red = cm;   grn = m5_i; blu = xm;   end
      SECT_BLACK: begin red = '0;   grn = '0;   blu = '0;   end
      default:    begin red = '0;   grn = '0;   blu = '0;   end
    endcase
    pixel_d = MarkerBit | {1'b0, red, grn, blu};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pixel_q <= pixel_d;
    end
  end

  assign pixel_o = pixel_q;

endmodule

[hdl/hsv_to_rgb555_pixel.sv]
`timescale 1ns / 1ps
// An accepted request passes the registers of stages A, B, C and D in order.
// Throughput: one request per cycle while the sink takes results; four
// register stages, each with its own valid bit, advance whenever the stage
// downstream is free.
// Reset: asynchronous active-low rst_ni clears the stage valid bits only;
// payload registers are not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb555_pixel: HSV colour to 16-bit LED pixel word
// Hue in 1/16 degree, saturation and brightness as n/255 go in; a word with
// bit 15 set and 5-bit red, green and blue comes out. Stages:
//   A  sector decode, hue fold, bri*sat and bri*(255-sat)
//   B  reciprocal scale of chroma/offset, weight product p*w
//   C  slice C5/M5, reciprocal multiply for X5
//   D  offset add, sector routing, pack (output register)
// A hue of 5760 or more gives black with the marker bit.
// ----------------------------------------------------------------------------
module hsv_to_rgb555_pixel (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis_tdata: [12:0] hue_sixteenths, [20:13] saturation,
  //               [28:21] brightness, [31:29] zero
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // m_axis_tdata: [15:0] pixel_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata
);
  import hsv_pkg::*;

  stage_en_t         en;
  logic              v_a_q, v_b_q, v_c_q, v_d_q;

  sector_e           sector_a, sector_c;
  logic [PosW-1:0]   pos_a;
  logic [ProdW-1:0]  cprod_a, mprod_a;
  logic [Chan5W-1:0] c5_c, m5_c;
  logic [XProdW-1:0] xprod_c;

  // Advance a stage when its slot is empty or its content moves on; the
  // output register holds while the sink stalls.
  always_comb begin
    en.en_d = !v_d_q || m_axis_tready;
    en.en_c = !v_c_q || en.en_d;
    en.en_b = !v_b_q || en.en_c;
    en.en_a = !v_a_q || en.en_b;
  end

  assign s_axis_tready = en.en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
    end else begin
      if (en.en_a) v_a_q <= s_axis_tvalid;
      if (en.en_b) v_b_q <= v_a_q;
      if (en.en_c) v_c_q <= v_b_q;
      if (en.en_d) v_d_q <= v_c_q;
    end
  end

  hsv_front u_front (
    .clk_i    (clk_i),
    .en_i     (en.en_a),
    .hue_i    (s_axis_tdata[HueW-1:0]),
    .sat_i    (s_axis_tdata[HueW +: ChanW]),
    .bri_i    (s_axis_tdata[HueW+ChanW +: ChanW]),
    .sector_o (sector_a),
    .pos_o    (pos_a),
    .cprod_o  (cprod_a),
    .mprod_o  (mprod_a)
  );

  hsv_scale u_scale (
    .clk_i    (clk_i),
    .en_i     (en),
    .sector_i (sector_a),
    .pos_i    (pos_a),
    .cprod_i  (cprod_a),
    .mprod_i  (mprod_a),
    .sector_o (sector_c),
    .c5_o     (c5_c),
    .m5_o     (m5_c),
    .xprod_o  (xprod_c)
  );

  hsv_mix u_mix (
    .clk_i    (clk_i),
    .en_i     (en.en_d),
    .sector_i (sector_c),
    .c5_i     (c5_c),
    .m5_i     (m5_c),
    .xprod_i  (xprod_c),
    .pixel_o  (m_axis_tdata)
  );

  assign m_axis_tvalid = v_d_q;

endmodule
